@@ src/rgda_pkg.sv @@
// shared types, constants and register codes for the row guidance delta average block
package rgda_pkg;

	// frame accumulator sizing
	localparam int MAX_ITEMS = 256;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W     = 12 + CNT_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERSPECTIVE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_SPACING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_SHIFT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_LINES   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EXTRA_RANGE  = 3'd7;

	// shared divider: numerator and denominator widths, two quotient bits per step
	localparam int DIV_NW    = 28;
	localparam int DIV_DW    = 16;
	localparam int DIV_CNT_W = $clog2(DIV_NW / 2 + 1);
	localparam int MOD_NW    = 18;
	localparam int AVG_NW    = ((SUM_W - 1 + 1) / 2) * 2;

	localparam logic [DIV_CNT_W-1:0] STEPS_PROJ = DIV_CNT_W'(DIV_NW / 2);
	localparam logic [DIV_CNT_W-1:0] STEPS_MOD  = DIV_CNT_W'(MOD_NW / 2);
	localparam logic [DIV_CNT_W-1:0] STEPS_AVG  = DIV_CNT_W'(AVG_NW / 2);

	// divider operations
	localparam logic [1:0] DOP_PROJ = 2'd0;
	localparam logic [1:0] DOP_MOD  = 2'd1;
	localparam logic [1:0] DOP_AVG  = 2'd2;

	typedef struct packed {
		logic       cap;
		logic       mul;
		logic       div_start;
		logic [1:0] div_op;
		logic       xo_ld;
		logic       fold;
		logic       acc;
		logic       avg_chk;
		logic       avg_ld;
		logic       out_ld;
	} rgda_cmd_t;

	typedef struct packed {
		logic px_zero;
		logic py_zero;
		logic in_range;
		logic frame_end;
		logic count_nz;
		logic div_done;
		logic out_free;
	} rgda_stat_t;

endpackage

@@ src/rgda_div.sv @@
// iterative unsigned divider, two quotient bits per cycle
module rgda_div import rgda_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_CNT_W-1:0] steps,
	input  logic [DIV_NW-1:0]    num,
	input  logic [DIV_DW-1:0]    den,
	output logic                 done,
	output logic [DIV_NW-1:0]    quot,
	output logic [DIV_DW-1:0]    rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NW-1:0]    num_q;
	logic [DIV_DW-1:0]    rem_q;
	logic [DIV_DW-1:0]    den_q;

	logic [DIV_DW:0]   t1, t2;
	logic              ge1, ge2;
	logic [DIV_DW-1:0] r1, r2;

	always_comb begin
		t1  = {rem_q, num_q[DIV_NW-1]};
		ge1 = t1 >= {1'b0, den_q};
		r1  = ge1 ? DIV_DW'(t1 - {1'b0, den_q}) : t1[DIV_DW-1:0];
		t2  = {r1, num_q[DIV_NW-2]};
		ge2 = t2 >= {1'b0, den_q};
		r2  = ge2 ? DIV_DW'(t2 - {1'b0, den_q}) : t2[DIV_DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NW-3:0], ge1, ge2};
			rem_q <= r2;
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule

@@ src/rgda_dp.sv @@
// datapath: configuration, projection, folding, frame accumulator and output register
module rgda_dp import rgda_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [11:0]            plant_x,
	input  logic [11:0]            plant_y,
	input  logic                   frame_end,
	input  logic                   out_stall,
	input  rgda_cmd_t              cmd,
	output rgda_stat_t             stat,
	output logic                   out_valid,
	output logic                   projected,
	output logic signed [11:0]     line_delta,
	output logic                   in_threshold,
	output logic                   in_row_range,
	output logic                   frame_done,
	output logic                   average_valid,
	output logic signed [11:0]     average_delta
);

	localparam int XO_W = DIV_NW + 2;
	localparam logic signed [13:0] DELTA_MAX = 14'sd2047;
	localparam logic signed [13:0] DELTA_MIN = -14'sd2048;

	// configuration registers
	logic [10:0]        center_x_q;
	logic [14:0]        persp_q;
	logic [11:0]        rows_q;
	logic [11:0]        spacing_q;
	logic signed [12:0] shift_q;
	logic [4:0]         half_cnt_q;
	logic [11:0]        thresh_q;
	logic [11:0]        extra_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= 11'd320;
			persp_q    <= '0;
			rows_q     <= 12'd480;
			spacing_q  <= '0;
			shift_q    <= '0;
			half_cnt_q <= 5'd1;
			thresh_q   <= '0;
			extra_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X:     center_x_q <= cfg_data[10:0];
				REG_PERSPECTIVE:  persp_q    <= cfg_data[14:0];
				REG_SCREEN_ROWS:  rows_q     <= cfg_data[11:0];
				REG_LINE_SPACING: spacing_q  <= cfg_data[11:0];
				REG_LINE_SHIFT:   shift_q    <= $signed(cfg_data[12:0]);
				REG_HALF_LINES:   half_cnt_q <= cfg_data[4:0];
				REG_THRESHOLD:    thresh_q   <= cfg_data[11:0];
				REG_EXTRA_RANGE:  extra_q    <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// item and working registers
	logic [11:0]             x_q, y_q;
	logic                    fe_q;
	logic [DIV_NW-1:0]       prod_q;
	logic [16:0]             range_q;
	logic [15:0]             py_q;
	logic                    px_zero_q, py_zero_q, px_neg_q;
	logic signed [XO_W-1:0]  xo_q;
	logic                    proj_q, thr_q, rr_q;
	logic signed [11:0]      delta_q;
	logic                    avg_valid_q;
	logic signed [11:0]      avg_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        count_q;
	logic                    out_valid_q;

	// divider
	logic                 div_done;
	logic [DIV_NW-1:0]    div_quot;
	logic [DIV_DW-1:0]    div_rem;
	logic [DIV_CNT_W-1:0] div_steps;
	logic [DIV_NW-1:0]    div_num;
	logic [DIV_DW-1:0]    div_den;

	// projection
	logic signed [12:0] px;
	logic [11:0]        px_abs;
	logic [15:0]        py, yb;
	logic [DIV_NW-1:0]  prod;
	logic [16:0]        range_val;

	assign px        = $signed({1'b0, x_q}) - $signed({2'b0, center_x_q});
	assign px_abs    = px[12] ? 12'(-px) : px[11:0];
	assign py        = {1'b0, persp_q} + {4'b0, y_q};
	assign yb        = {1'b0, persp_q} + {4'b0, rows_q};
	assign prod      = yb * px_abs;
	assign range_val = 17'(spacing_q) * 17'(half_cnt_q) + 17'(spacing_q >> 1);

	// baseline x and offset
	logic [XO_W-1:0]        quot_ext;
	logic signed [XO_W-1:0] xb, xo_next;
	logic                   xo_neg;
	logic [XO_W-1:0]        xo_abs;

	assign quot_ext = XO_W'(div_quot);
	assign xb       = px_zero_q ? '0 :
	                  (px_neg_q ? -$signed(quot_ext) : $signed(quot_ext));
	assign xo_next  = xb - XO_W'(shift_q);
	assign xo_neg   = xo_q[XO_W-1];
	assign xo_abs   = xo_neg ? XO_W'(-xo_q) : xo_q;

	// folding onto the nearest line
	logic signed [13:0] r, sp14, half14, d14;
	logic signed [11:0] d_sat;
	logic [12:0]        ad;
	logic               thr_next, rr_next;

	always_comb begin
		r      = xo_neg ? -$signed({2'b0, div_rem[11:0]}) : $signed({2'b0, div_rem[11:0]});
		sp14   = $signed({2'b0, spacing_q});
		half14 = $signed({3'b0, spacing_q[11:1]});
		priority if (r >= half14)
			d14 = r - sp14;
		else if (r <= -half14)
			d14 = r + sp14;
		else
			d14 = r;
		priority if (d14 > DELTA_MAX)
			d_sat = DELTA_MAX[11:0];
		else if (d14 < DELTA_MIN)
			d_sat = DELTA_MIN[11:0];
		else
			d_sat = d14[11:0];
		ad       = d_sat[11] ? 13'(-$signed({d_sat[11], d_sat})) : {1'b0, d_sat};
		thr_next = ad <= {1'b0, thresh_q};
		rr_next  = (extra_q == '0) || (ad <= {1'b0, thresh_q} + {1'b0, extra_q});
	end

	// frame average
	logic                    sum_neg;
	logic [SUM_W-1:0]        sum_abs;
	logic [11:0]             avg_mag;

	assign sum_neg = sum_q[SUM_W-1];
	assign sum_abs = sum_neg ? SUM_W'(-sum_q) : sum_q;
	assign avg_mag = div_quot[11:0];

	// divider operand select
	always_comb begin
		unique case (cmd.div_op)
			DOP_MOD: begin
				div_steps = STEPS_MOD;
				div_num   = DIV_NW'(xo_abs[MOD_NW-1:0]) << (DIV_NW - MOD_NW);
				div_den   = DIV_DW'(spacing_q);
			end
			DOP_AVG: begin
				div_steps = STEPS_AVG;
				div_num   = DIV_NW'(sum_abs[SUM_W-2:0]) << (DIV_NW - AVG_NW);
				div_den   = DIV_DW'(count_q);
			end
			default: begin
				div_steps = STEPS_PROJ;
				div_num   = prod_q;
				div_den   = py_q;
			end
		endcase
	end

	rgda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.steps  (div_steps),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			x_q     <= plant_x;
			y_q     <= plant_y;
			fe_q    <= frame_end;
			proj_q  <= 1'b0;
			delta_q <= '0;
			thr_q   <= 1'b0;
			rr_q    <= 1'b0;
		end
		if (cmd.mul) begin
			prod_q    <= prod;
			range_q   <= range_val;
			py_q      <= py;
			px_zero_q <= (px == '0);
			py_zero_q <= (py == '0);
			px_neg_q  <= px[12];
		end
		if (cmd.xo_ld)
			xo_q <= xo_next;
		if (cmd.fold) begin
			proj_q  <= 1'b1;
			delta_q <= d_sat;
			thr_q   <= thr_next;
			rr_q    <= rr_next;
		end
		if (cmd.avg_chk) begin
			avg_valid_q <= fe_q && (count_q != '0);
			avg_q       <= '0;
		end
		if (cmd.avg_ld)
			avg_q <= sum_neg ? 12'(-$signed(avg_mag)) : $signed(avg_mag);
		if (cmd.out_ld) begin
			projected     <= proj_q;
			line_delta    <= delta_q;
			in_threshold  <= thr_q;
			in_row_range  <= rr_q;
			frame_done    <= fe_q;
			average_valid <= avg_valid_q;
			average_delta <= avg_q;
		end
	end

	// accumulator and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.acc && proj_q && rr_q && (count_q < CNT_W'(MAX_ITEMS))) begin
				sum_q   <= sum_q + SUM_W'(delta_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.out_ld && fe_q) begin
				sum_q   <= '0;
				count_q <= '0;
			end
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.px_zero   = px_zero_q;
	assign stat.py_zero   = py_zero_q;
	assign stat.in_range  = xo_abs < XO_W'(range_q);
	assign stat.frame_end = fe_q;
	assign stat.count_nz  = count_q != '0;
	assign stat.div_done  = div_done;
	assign stat.out_free  = !out_valid_q || !out_stall;

endmodule

@@ src/rgda_ctrl.sv @@
// controller: sequences one item through projection, folding, accumulation, frame average and output
module rgda_ctrl import rgda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  rgda_stat_t stat,
	output rgda_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_DIVP = 4'd3;
	localparam logic [3:0] S_XO   = 4'd4;
	localparam logic [3:0] S_RNG  = 4'd5;
	localparam logic [3:0] S_DIVM = 4'd6;
	localparam logic [3:0] S_ACC  = 4'd7;
	localparam logic [3:0] S_AVG  = 4'd8;
	localparam logic [3:0] S_DIVA = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.div_op = DOP_PROJ;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				priority if (stat.px_zero)
					state_d = S_XO;
				else if (stat.py_zero)
					state_d = S_ACC;
				else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DOP_PROJ;
					state_d       = S_DIVP;
				end
			end
			S_DIVP: begin
				if (stat.div_done)
					state_d = S_XO;
			end
			S_XO: begin
				cmd.xo_ld = 1'b1;
				state_d   = S_RNG;
			end
			S_RNG: begin
				if (stat.in_range) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DOP_MOD;
					state_d       = S_DIVM;
				end else begin
					state_d = S_ACC;
				end
			end
			S_DIVM: begin
				if (stat.div_done) begin
					cmd.fold = 1'b1;
					state_d  = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_AVG;
			end
			S_AVG: begin
				cmd.avg_chk = 1'b1;
				if (stat.frame_end && stat.count_nz) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DOP_AVG;
					state_d       = S_DIVA;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DIVA: begin
				if (stat.div_done) begin
					cmd.avg_ld = 1'b1;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				// wait until the output register is free
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_stall = state_q != S_IDLE;

endmodule

@@ src/row_guidance_delta_average.sv @@
// row guidance delta average: top level joining controller and datapath
// one item at a time: each item passes through the divisions it needs on the
// shared two-bit-per-cycle divider (14 steps projection, 9 fold, 10 average)
// next item can be accepted in the cycle after the result loads
// an item is accepted while the previous result still waits in the output register
// reset clears configuration to defaults, frame sum and count, and the handshake state
module row_guidance_delta_average import rgda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [11:0]           plant_x,
	input  logic [11:0]           plant_y,
	input  logic                  frame_end,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  projected,
	output logic signed [11:0]    line_delta,
	output logic                  in_threshold,
	output logic                  in_row_range,
	output logic                  frame_done,
	output logic                  average_valid,
	output logic signed [11:0]    average_delta
);

	rgda_cmd_t  cmd;
	rgda_stat_t stat;

	rgda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rgda_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.plant_x       (plant_x),
		.plant_y       (plant_y),
		.frame_end     (frame_end),
		.out_stall     (out_stall),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.projected     (projected),
		.line_delta    (line_delta),
		.in_threshold  (in_threshold),
		.in_row_range  (in_row_range),
		.frame_done    (frame_done),
		.average_valid (average_valid),
		.average_delta (average_delta)
	);

endmodule
